@@ rtl/pdht_pkg.sv @@
// Package for the plane dedup hash table: sizes, codes, state and
// record types shared by the table engine and the top level.
// No dependencies.
package pdht_pkg;

  localparam int PlaneCapacity = 2048;
  localparam int HashBuckets   = 1024;
  localparam int IdxW  = $clog2(PlaneCapacity);
  localparam int LinkW = IdxW + 1;
  localparam int BktW  = $clog2(HashBuckets);

  typedef enum logic [1:0] {
    OP_FIND  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_NORMAL_TOL = 2'd0,
    CFG_DIST_TOL   = 2'd1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_HEAD_RD,
    ST_HEAD_WAIT,
    ST_ENT_RD,
    ST_ENT_WAIT,
    ST_ENT_CMP,
    ST_INSERT,
    ST_READ_WAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic signed [31:0] plane_dist;
    logic [2:0]         signs;
    logic [LinkW-1:0]   next;
  } entry_t;

  typedef struct packed {
    logic [IdxW-1:0]    plane_index;
    logic               flipped;
    logic               created;
    logic [2:0]         sign_bits;
    logic               table_full;
    logic signed [15:0] out_normal_x;
    logic signed [15:0] out_normal_y;
    logic signed [15:0] out_normal_z;
    logic signed [31:0] out_distance;
  } result_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [31:0] distance;
    logic [IdxW-1:0]    read_index;
  } request_t;

endpackage

@@ rtl/pdht_engine.sv @@
// Table engine: entry memory, bucket head memory and the walk sequencer.
// Depends on pdht_pkg.
module pdht_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  pdht_pkg::request_t req,
  input  logic [7:0]        normal_tol,
  input  logic [15:0]       dist_tol,
  output logic              busy,
  output logic              done,
  output pdht_pkg::result_t res
);
  import pdht_pkg::*;

  entry_t           ent_mem [PlaneCapacity];
  logic [LinkW-1:0] head_mem [HashBuckets];

  state_t state, state_next;
  request_t rq;
  logic [LinkW-1:0] count;
  logic [1:0] bkt_sel;
  logic [BktW-1:0] hash;
  logic [LinkW-1:0] link;
  logic [LinkW-1:0] steps;
  logic [BktW-1:0] sweep_addr;
  logic sweep_busy;
  logic clear_reply;
  entry_t ent_q;
  logic [LinkW-1:0] head_q;
  result_t res_r;

  // memory ports
  logic ent_we;
  logic [IdxW-1:0] ent_addr;
  entry_t ent_wd;
  logic head_we;
  logic [BktW-1:0] head_addr;
  logic [LinkW-1:0] head_wd;

  always_ff @(posedge clk) begin
    if (ent_we) ent_mem[ent_addr] <= ent_wd;
    ent_q <= ent_mem[ent_addr];
  end
  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_addr] <= head_wd;
    head_q <= head_mem[head_addr];
  end

  // compare
  logic signed [16:0] dx, dy, dz, fx, fy, fz;
  logic signed [33:0] dd, fd;
  logic [16:0] adx, ady, adz, afx, afy, afz;
  logic [33:0] add_, afd;
  logic hit_same, hit_flip;
  always_comb begin
    dx = 17'(ent_q.nx) - 17'(rq.normal_x);
    dy = 17'(ent_q.ny) - 17'(rq.normal_y);
    dz = 17'(ent_q.nz) - 17'(rq.normal_z);
    dd = 34'(ent_q.plane_dist) - 34'(rq.distance);
    fx = 17'(ent_q.nx) + 17'(rq.normal_x);
    fy = 17'(ent_q.ny) + 17'(rq.normal_y);
    fz = 17'(ent_q.nz) + 17'(rq.normal_z);
    fd = 34'(ent_q.plane_dist) + 34'(rq.distance);
    adx = dx[16] ? 17'(-dx) : 17'(dx);
    ady = dy[16] ? 17'(-dy) : 17'(dy);
    adz = dz[16] ? 17'(-dz) : 17'(dz);
    add_ = dd[33] ? 34'(-dd) : 34'(dd);
    afx = fx[16] ? 17'(-fx) : 17'(fx);
    afy = fy[16] ? 17'(-fy) : 17'(fy);
    afz = fz[16] ? 17'(-fz) : 17'(fz);
    afd = fd[33] ? 34'(-fd) : 34'(fd);
    hit_same = adx < 17'(normal_tol) && ady < 17'(normal_tol) &&
               adz < 17'(normal_tol) && add_ < 34'(dist_tol);
    hit_flip = afx < 17'(normal_tol) && afy < 17'(normal_tol) &&
               afz < 17'(normal_tol) && afd < 34'(dist_tol);
  end

  logic [31:0] abs_d;
  logic [BktW-1:0] req_hash;
  assign abs_d = req.distance[31] ? 32'(-req.distance) : 32'(req.distance);
  assign req_hash = abs_d[11 +: BktW];

  logic link_ok;
  assign link_ok = link != '0 && link <= count && steps < count;

  logic [BktW-1:0] cur_bkt;
  assign cur_bkt = hash + BktW'(bkt_sel) - BktW'(1);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_SWEEP: if (sweep_addr == BktW'(HashBuckets - 1)) begin
        state_next = clear_reply ? ST_DONE : ST_IDLE;
      end
      ST_IDLE: if (start) begin
        case (op_t'(req.operation))
          OP_FIND:  state_next = ST_HEAD_RD;
          OP_CLEAR: state_next = ST_SWEEP;
          OP_READ:  state_next = ST_READ_WAIT;
          default:  state_next = ST_DONE;
        endcase
      end
      ST_HEAD_RD:   state_next = ST_HEAD_WAIT;
      ST_HEAD_WAIT: state_next = ST_ENT_RD;
      ST_ENT_RD: begin
        if (link_ok) state_next = ST_ENT_WAIT;
        else if (bkt_sel == 2'd2) state_next = ST_INSERT;
        else state_next = ST_HEAD_RD;
      end
      ST_ENT_WAIT:  state_next = ST_ENT_CMP;
      ST_ENT_CMP:   state_next = (hit_same || hit_flip) ? ST_DONE : ST_ENT_RD;
      ST_INSERT:    state_next = ST_DONE;
      ST_READ_WAIT: state_next = ST_DONE;
      ST_DONE:      state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ent_we = 1'b0;
    ent_addr = link[IdxW-1:0] - IdxW'(1);
    ent_wd = '{nx: rq.normal_x, ny: rq.normal_y, nz: rq.normal_z, plane_dist: rq.distance,
               signs: {rq.normal_z[15], rq.normal_y[15], rq.normal_x[15]}, next: head_q};
    head_we = 1'b0;
    head_addr = cur_bkt;
    head_wd = count + LinkW'(1);
    unique case (state)
      ST_IDLE: if (start) ent_addr = req.read_index;
      ST_SWEEP: begin
        head_we = 1'b1;
        head_addr = sweep_addr;
        head_wd = '0;
      end
      ST_ENT_RD: head_addr = hash;
      ST_INSERT: begin
        head_addr = hash;
        if (count < LinkW'(PlaneCapacity)) begin
          ent_we = 1'b1;
          ent_addr = count[IdxW-1:0];
          head_we = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign sweep_busy = state == ST_SWEEP;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SWEEP;
      sweep_addr <= '0;
      count <= '0;
      clear_reply <= 1'b0;
    end else begin
      state <= state_next;
      if (sweep_busy) sweep_addr <= sweep_addr + BktW'(1);
      if (state == ST_IDLE && start && op_t'(req.operation) == OP_CLEAR) begin
        count <= '0;
        sweep_addr <= '0;
        clear_reply <= 1'b1;
      end
      if (state == ST_INSERT && count < LinkW'(PlaneCapacity)) count <= count + LinkW'(1);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: if (start) begin
        rq <= req;
        hash <= req_hash;
        bkt_sel <= '0;
        res_r <= '{plane_index: (op_t'(req.operation) == OP_READ) ? req.read_index : '0,
                   default: '0};
      end
      ST_HEAD_WAIT: begin
        link <= head_q;
        steps <= '0;
      end
      ST_ENT_RD: if (!link_ok) bkt_sel <= bkt_sel + 2'd1;
      ST_ENT_CMP: begin
        if (hit_same || hit_flip) begin
          res_r.plane_index <= link[IdxW-1:0] - IdxW'(1);
          res_r.flipped <= !hit_same;
          res_r.sign_bits <= ent_q.signs;
        end
        link <= ent_q.next;
        steps <= steps + LinkW'(1);
      end
      ST_INSERT: begin
        if (count < LinkW'(PlaneCapacity)) begin
          res_r.plane_index <= count[IdxW-1:0];
          res_r.created <= 1'b1;
          res_r.sign_bits <= ent_wd.signs;
        end else res_r.table_full <= 1'b1;
      end
      ST_READ_WAIT: if (LinkW'(rq.read_index) < count) begin
        res_r.sign_bits <= ent_q.signs;
        res_r.out_normal_x <= ent_q.nx;
        res_r.out_normal_y <= ent_q.ny;
        res_r.out_normal_z <= ent_q.nz;
        res_r.out_distance <= ent_q.plane_dist;
      end
      default: ;
    endcase
  end

  // bucket heads are read in HEAD_RD and captured in HEAD_WAIT; ENT_RD reads
  // the head of the request's own bucket so INSERT links the new entry in
  // front of it
  assign busy = state != ST_IDLE;
  assign done = state == ST_DONE;
  assign res = res_r;
endmodule

@@ rtl/plane_dedup_hash_table.sv @@
// Top level of the plane dedup hash table: stream ports, config
// registers, output register. Depends on pdht_pkg and pdht_engine.
//
// channel   dir  payload
// s_axis    in   tdata: operation, normal_x/y/z, distance, read_index
// m_axis    out  tdata: plane_index, flipped, created, sign_bits,
//                table_full, out_normal_x/y/z, out_distance
// cfg       in   index (0 normal_tolerance, 1 dist_tolerance), data
//
// One request at a time. Find searches the request's bucket and the one on
// either side, comparing chain entries until one matches, and on a miss
// inserts a new entry unless the table is full; read returns one stored
// entry; clear sweeps all 1024 bucket heads to zero. After reset the same
// sweep runs with s_axis_tready low. The result register holds while
// m_axis_tready is low; the next request is taken once the result has left.
module plane_dedup_hash_table (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // operation[1:0], normal_x[17:2], normal_y[33:18], normal_z[49:34],
  // distance[81:50], read_index[92:82]
  input  logic [95:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // plane_index[10:0], flipped[11], created[12], sign_bits[15:13],
  // table_full[16], out_normal_x[32:17], out_normal_y[48:33],
  // out_normal_z[64:49], out_distance[96:65]
  output logic [103:0] m_axis_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import pdht_pkg::*;

  logic [7:0]  normal_tol;
  logic [15:0] dist_tol;
  logic busy, done, out_valid;
  request_t req;
  result_t res, out_res;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      normal_tol <= 8'd2;
      dist_tol <= 16'd5;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_NORMAL_TOL: normal_tol <= cfg_data[7:0];
        CFG_DIST_TOL:   dist_tol <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign req = '{operation: s_axis_tdata[1:0], normal_x: s_axis_tdata[17:2],
                 normal_y: s_axis_tdata[33:18], normal_z: s_axis_tdata[49:34],
                 distance: s_axis_tdata[81:50], read_index: s_axis_tdata[92:82]};

  // take a new request only when the engine is idle and the output slot is free
  assign s_axis_tready = !busy && !out_valid;

  pdht_engine u_engine (
    .clk, .rst, .start(s_axis_tvalid && s_axis_tready), .req,
    .normal_tol, .dist_tol, .busy, .done, .res
  );

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (done) out_valid <= 1'b1;
    else if (m_axis_tready) out_valid <= 1'b0;
  end
  always_ff @(posedge clk) if (done) out_res <= res;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = {7'd0, out_res.out_distance, out_res.out_normal_z,
                         out_res.out_normal_y, out_res.out_normal_x, out_res.table_full,
                         out_res.sign_bits, out_res.created, out_res.flipped,
                         out_res.plane_index};
endmodule

@@ rtl/pdht_checker.sv @@
// Port checker for the plane dedup hash table, bound to the top level.
// Depends on plane_dedup_hash_table ports only.
module pdht_props (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [103:0] m_axis_tdata
);
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second request taken while busy");
  a_no_take_while_out: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("request taken with result pending");
  a_flags: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[16] && (m_axis_tdata[12] || m_axis_tdata[11])))
    else $error("full result with created or flipped");
endmodule

bind plane_dedup_hash_table pdht_props u_pdht_props (
  .clk, .rst, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
  .m_axis_tdata
);

@@ sim/pdht_checker.sv @@
// Scoreboard for the plane dedup hash table: watches the request, result and
// register channels, predicts every result and compares it field by field.
// Depends on pdht_pkg.
`timescale 1ns / 1ps

module pdht_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [103:0] m_axis_tdata,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  output int           errors,
  output int           pending
);
  import pdht_pkg::*;

  // Shadow of the table
  logic signed [15:0] tbl_nx   [PlaneCapacity];
  logic signed [15:0] tbl_ny   [PlaneCapacity];
  logic signed [15:0] tbl_nz   [PlaneCapacity];
  logic signed [31:0] tbl_dist [PlaneCapacity];
  logic [2:0]         tbl_sign [PlaneCapacity];
  int                 tbl_next [PlaneCapacity];
  int                 heads    [HashBuckets];
  int                 stored;
  longint             norm_tol;
  longint             dist_tol;

  result_t expected_results[$];

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic bit plane_near(int e, longint a, longint b, longint c, longint d);
    return mag(longint'(tbl_nx[e]) - a) < norm_tol &&
           mag(longint'(tbl_ny[e]) - b) < norm_tol &&
           mag(longint'(tbl_nz[e]) - c) < norm_tol &&
           mag(longint'(tbl_dist[e]) - d) < dist_tol;
  endfunction

  function automatic result_t lookup_plane(request_t r);
    result_t res;
    longint  a, b, c, d;
    int      hash, bkt, link, steps, e;
    logic [2:0] s;
    res = '0;
    case (op_t'(r.operation))
      OP_CLEAR: begin
        foreach (heads[i]) heads[i] = 0;
        stored = 0;
      end
      OP_READ: begin
        res.plane_index = r.read_index;
        if (r.read_index < stored) begin
          res.sign_bits    = tbl_sign[r.read_index];
          res.out_normal_x = tbl_nx[r.read_index];
          res.out_normal_y = tbl_ny[r.read_index];
          res.out_normal_z = tbl_nz[r.read_index];
          res.out_distance = tbl_dist[r.read_index];
        end
      end
      OP_FIND: begin
        a = r.normal_x;
        b = r.normal_y;
        c = r.normal_z;
        d = r.distance;
        hash = int'((mag(d) >> 11) & (HashBuckets - 1));
        for (int off = -1; off <= 1; off++) begin
          bkt = (hash + off + HashBuckets) & (HashBuckets - 1);
          link = heads[bkt];
          steps = 0;
          while (link != 0 && link <= stored && steps < stored) begin
            e = link - 1;
            if (plane_near(e, a, b, c, d) || plane_near(e, -a, -b, -c, -d)) begin
              res.plane_index = IdxW'(e);
              res.flipped = !plane_near(e, a, b, c, d);
              res.sign_bits = tbl_sign[e];
              return res;
            end
            link = tbl_next[e];
            steps++;
          end
        end
        if (stored >= PlaneCapacity) begin
          res.table_full = 1'b1;
          return res;
        end
        s = {r.normal_z < 0, r.normal_y < 0, r.normal_x < 0};
        tbl_nx[stored] = r.normal_x;
        tbl_ny[stored] = r.normal_y;
        tbl_nz[stored] = r.normal_z;
        tbl_dist[stored] = r.distance;
        tbl_sign[stored] = s;
        tbl_next[stored] = heads[hash];
        heads[hash] = stored + 1;
        res.plane_index = IdxW'(stored);
        res.created = 1'b1;
        res.sign_bits = s;
        stored++;
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    request_t req;
    result_t  got, exp_res;
    if (rst) begin
      expected_results.delete();
      foreach (heads[i]) heads[i] = 0;
      stored = 0;
      norm_tol = 2;
      dist_tol = 5;
      errors = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_idx_t'(cfg_index) == CFG_NORMAL_TOL) norm_tol = cfg_data[7:0];
        else if (cfg_idx_t'(cfg_index) == CFG_DIST_TOL) dist_tol = cfg_data[15:0];
      end
      if (s_axis_tvalid && s_axis_tready) begin
        req.operation  = s_axis_tdata[1:0];
        req.normal_x   = s_axis_tdata[17:2];
        req.normal_y   = s_axis_tdata[33:18];
        req.normal_z   = s_axis_tdata[49:34];
        req.distance   = s_axis_tdata[81:50];
        req.read_index = s_axis_tdata[92:82];
        expected_results.push_back(lookup_plane(req));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.plane_index  = m_axis_tdata[10:0];
        got.flipped      = m_axis_tdata[11];
        got.created      = m_axis_tdata[12];
        got.sign_bits    = m_axis_tdata[15:13];
        got.table_full   = m_axis_tdata[16];
        got.out_normal_x = m_axis_tdata[32:17];
        got.out_normal_y = m_axis_tdata[48:33];
        got.out_normal_z = m_axis_tdata[64:49];
        got.out_distance = m_axis_tdata[96:65];
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10) $display("ERROR: unexpected result %p", got);
        end else begin
          exp_res = expected_results.pop_front();
          if (got.plane_index !== exp_res.plane_index || got.flipped !== exp_res.flipped ||
              got.created !== exp_res.created || got.sign_bits !== exp_res.sign_bits ||
              got.table_full !== exp_res.table_full ||
              got.out_normal_x !== exp_res.out_normal_x ||
              got.out_normal_y !== exp_res.out_normal_y ||
              got.out_normal_z !== exp_res.out_normal_z ||
              got.out_distance !== exp_res.out_distance) begin
            errors++;
            if (errors <= 10) $display("ERROR: expected %p, got %p", exp_res, got);
          end
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

@@ sim/tb_plane_dedup_hash_table.sv @@
// Top of the plane dedup hash table bench: clock, reset, request stimulus,
// register writes and verdict. Depends on pdht_pkg, pdht_checker and the block.
`timescale 1ns / 1ps

module tb_plane_dedup_hash_table;
  import pdht_pkg::*;

  localparam int CycleLimit = 4000000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [95:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;
  int           errors;
  int           pending;
  int           cycles = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;

  // Recently sent planes, reused with small offsets to provoke matches
  logic signed [15:0] hist_n[$][3];
  logic signed [31:0] hist_d[$];

  always #5 clk = ~clk;

  plane_dedup_hash_table i_dut (.*);

  pdht_checker i_checker (.*);

  // Watchdog: give up if the run hangs
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: stall at random, per the current phase
  always @(negedge clk)
    m_axis_tready <= !rst && ($urandom_range(0, 99) >= recv_stall_pct);

  // Drive one request and hold it until the block takes it
  task automatic send_request(op_t op, logic signed [15:0] nx, logic signed [15:0] ny,
                              logic signed [15:0] nz, logic signed [31:0] d,
                              logic [10:0] idx);
    while ($urandom_range(0, 99) < send_idle_pct) @(negedge clk);
    s_axis_tdata  = {3'b0, idx, d, nz, ny, nx, op};
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    if (op == OP_FIND) begin
      hist_n.push_back('{nx, ny, nz});
      hist_d.push_back(d);
      if (hist_d.size() > 64) begin
        void'(hist_n.pop_front());
        void'(hist_d.pop_front());
      end
    end
  endtask

  task automatic find_plane(logic signed [15:0] nx, logic signed [15:0] ny,
                            logic signed [15:0] nz, logic signed [31:0] d);
    send_request(OP_FIND, nx, ny, nz, d, '0);
  endtask

  // Write both tolerances; only called with nothing outstanding
  task automatic set_tolerances(logic [7:0] ntol, logic [15:0] dtol);
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    for (int i = 0; i < 2; i++) begin
      cfg_index = (i == 0) ? CFG_NORMAL_TOL : CFG_DIST_TOL;
      // junk in the upper bits must be dropped
      cfg_data  = (i == 0) ? {24'($urandom_range(0, 16777215)), ntol}
                           : {16'($urandom), dtol};
      cfg_valid = 1'b1;
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
      cfg_valid = 1'b0;
    end
  endtask

  function automatic logic signed [15:0] rand_normal();
    case ($urandom_range(0, 7))
      0:       return 16'sd16384;
      1:       return -16'sd16384;
      2:       return 16'sd0;
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  function automatic logic signed [15:0] nudge(logic signed [15:0] v, int span);
    int r;
    r = int'(v) + $signed($urandom_range(0, 2 * span)) - span;
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return 16'(r);
  endfunction

  task automatic random_request();
    int sel, k;
    logic signed [15:0] a, b, c;
    logic signed [31:0] d;
    sel = $urandom_range(0, 99);
    if (sel < 2) begin
      send_request(OP_CLEAR, rand_normal(), rand_normal(), rand_normal(), $urandom,
                   11'($urandom));
    end else if (sel < 4) begin
      send_request(OP_NONE, rand_normal(), rand_normal(), rand_normal(), $urandom,
                   11'($urandom));
    end else if (sel < 16) begin
      send_request(OP_READ, rand_normal(), rand_normal(), rand_normal(), $urandom,
                   ($urandom_range(0, 3) == 0) ? 11'($urandom) : 11'($urandom_range(0, 63)));
    end else if (sel < 60 && hist_d.size() > 0) begin
      // revisit a recent plane, near or negated
      k = $urandom_range(0, hist_d.size() - 1);
      a = nudge(hist_n[k][0], 3);
      b = nudge(hist_n[k][1], 3);
      c = nudge(hist_n[k][2], 3);
      d = hist_d[k] + $signed($urandom_range(0, 12)) - 6;
      if ($urandom_range(0, 1)) find_plane(-a, -b, -c, -d);
      else find_plane(a, b, c, d);
    end else begin
      d = ($urandom_range(0, 3) == 0) ? $signed($urandom_range(0, 40000)) - 20000 : $urandom;
      find_plane(rand_normal(), rand_normal(), rand_normal(), d);
    end
  endtask

  initial begin
    logic [7:0]  ntol [8] = '{8'd2, 8'd1, 8'd255, 8'd0, 8'd8, 8'd255, 8'd1, 8'd40};
    logic [15:0] dtol [8] = '{16'd5, 16'd1, 16'd65535, 16'd0, 16'd300, 16'd1,
                              16'd65535, 16'd2000};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: extremes, exact and flipped matches, every operation
    find_plane(16'sd16384, 16'sd0, 16'sd0, 32'sd0);
    find_plane(-16'sd16384, 16'sd0, 16'sd0, 32'sd0);
    find_plane(16'sd0, 16'sd16384, -16'sd16384, 32'h7FFFFFFF);
    find_plane(16'sd0, -16'sd16384, 16'sd16384, 32'h80000000);
    find_plane(16'sd0, -16'sd16384, 16'sd16384, -32'sh7FFFFFFF);
    find_plane(16'sd0, 16'sd16384, -16'sd16384, 32'h80000001);
    find_plane(16'sd100, 16'sd200, 16'sd300, 32'sd2047);
    find_plane(16'sd101, 16'sd199, 16'sd301, 32'sd2051);
    find_plane(-16'sd101, -16'sd201, -16'sd299, -32'sd2049);
    find_plane(16'sd100, 16'sd200, 16'sd300, 32'sd2048);
    find_plane(16'sd100, 16'sd200, 16'sd302, 32'sd2047);
    find_plane(-16'sd5, -16'sd7, -16'sd9, 32'sd4095);
    send_request(OP_READ, '0, '0, '0, '0, 11'd0);
    send_request(OP_READ, '0, '0, '0, '0, 11'd3);
    send_request(OP_READ, '0, '0, '0, '0, 11'd2047);
    send_request(OP_NONE, -16'sd1, -16'sd1, -16'sd1, -32'sd1, 11'h7FF);
    send_request(OP_CLEAR, '0, '0, '0, '0, '0);
    send_request(OP_READ, '0, '0, '0, '0, 11'd0);
    find_plane(16'sd100, 16'sd200, 16'sd300, 32'sd2047);

    // Random phases across tolerance settings and idle patterns
    for (int p = 0; p < 8; p++) begin
      set_tolerances(ntol[p], dtol[p]);
      send_idle_pct  = (p % 4 == 1) ? 75 : (p % 4 == 3) ? 24 : 0;
      recv_stall_pct = (p % 4 == 2) ? 75 : (p % 4 == 3) ? 24 : 0;
      repeat (125) random_request();
    end

    // Empty the table and run a short random tail
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hist_d.delete();
    hist_n.delete();
    send_request(OP_CLEAR, '0, '0, '0, '0, '0);
    repeat (20) random_request();

    // Drain, then let the block settle
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
